>>> sv/polyline_pen_convolution_defines.svh
// ---------------------------------------------------------------------------
// Polyline pen convolution assertion macros
// Shared concurrent assertion forms for the controller.
// ---------------------------------------------------------------------------
`ifndef POLYLINE_PEN_CONVOLUTION_DEFINES_SVH
`define POLYLINE_PEN_CONVOLUTION_DEFINES_SVH

// same-cycle implication
`define PPC_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ppc assertion failed");

// next-cycle implication
`define PPC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ppc assertion failed");

`endif

>>> sv/ppc_pkg.sv
// ---------------------------------------------------------------------------
// Polyline pen convolution package
// Shared constants, command codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppc_pkg;

   localparam int PEN_POINTS_DEF    = 16;
   localparam int STROKE_POINTS_DEF = 64;

   localparam logic [1:0] CMD_LOAD_PEN    = 2'd0;
   localparam logic [1:0] CMD_LOAD_STROKE = 2'd1;
   localparam logic [1:0] CMD_PULL        = 2'd2;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } point_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LM_RD_A,
      OP_LM_RD_B,
      OP_LM_NORM,
      OP_SCAN_RD,
      OP_SCAN_MUL,
      OP_SCAN_ACC,
      OP_INIT,
      OP_RD_CUR,
      OP_SUM,
      OP_RD_NEXT,
      OP_RD_PREV,
      OP_CROSS1,
      OP_CROSS2,
      OP_DECIDE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      clear;
      logic      second;
      logic      cap_step;
      logic      turn;
      logic      emit;
      logic      mv;
      logic      fin;
   } dp_cmd_type;

   typedef struct packed {
      logic stroke_start;
      logic scan_last;
      logic s_at_goal;
      logic p_at_goal;
      logic backward;
   } dp_status_type;

endpackage

>>> sv/ppc_ram.sv
// ---------------------------------------------------------------------------
// Polyline pen convolution generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> sv/ppc_ctrl.sv
// ---------------------------------------------------------------------------
// Polyline pen convolution controller
// Sequences loads, the leftmost-vertex searches and each outline pull.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polyline_pen_convolution_defines.svh"

module ppc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_command,
   output logic                   busy,
   output ppc_pkg::dp_cmd_type    cmd,
   input  ppc_pkg::dp_status_type status
);

   typedef enum logic [16:0] {
      ST_IDLE     = 17'h00001,
      ST_LM_RDA   = 17'h00002,
      ST_LM_RDB   = 17'h00004,
      ST_LM_NORM  = 17'h00008,
      ST_SCAN_RD  = 17'h00010,
      ST_SCAN_MUL = 17'h00020,
      ST_SCAN_ACC = 17'h00040,
      ST_INIT     = 17'h00080,
      ST_RD_CUR   = 17'h00100,
      ST_SUM      = 17'h00200,
      ST_RD_NEXT  = 17'h00400,
      ST_RD_PREV  = 17'h00800,
      ST_CROSS1   = 17'h01000,
      ST_CROSS2   = 17'h02000,
      ST_DECIDE   = 17'h04000,
      ST_CAP_STEP = 17'h08000,
      ST_FIN      = 17'h10000
   } state_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_MOVE = 5'b00010,
      PH_WALK = 5'b00100,
      PH_CAP  = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      second_ff, second_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      second_in    = second_ff;
      cmd.op       = ppc_pkg::OP_NONE;
      cmd.clear    = 1'b0;
      cmd.second   = second_ff;
      cmd.cap_step = 1'b0;
      cmd.turn     = 1'b0;
      cmd.emit     = 1'b0;
      cmd.mv       = 1'b0;
      cmd.fin      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op    = ppc_pkg::OP_ACCEPT;
               cmd.clear = (phase_ff != PH_IDLE);
               if (req_command inside {ppc_pkg::CMD_LOAD_PEN, ppc_pkg::CMD_LOAD_STROKE}) begin
                  phase_in = PH_IDLE;
                  if (status.stroke_start) begin
                     second_in = 1'b0;
                     state_in  = ST_LM_RDA;
                  end
               end else if (req_command == ppc_pkg::CMD_PULL) begin
                  if (phase_ff inside {PH_MOVE, PH_WALK}) begin
                     state_in = ST_RD_CUR;
                  end else if (phase_ff == PH_CAP) begin
                     state_in = ST_CAP_STEP;
                  end
               end
            end
         end
         ST_LM_RDA: begin
            cmd.op   = ppc_pkg::OP_LM_RD_A;
            state_in = ST_LM_RDB;
         end
         ST_LM_RDB: begin
            cmd.op   = ppc_pkg::OP_LM_RD_B;
            state_in = ST_LM_NORM;
         end
         ST_LM_NORM: begin
            cmd.op   = ppc_pkg::OP_LM_NORM;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            cmd.op   = ppc_pkg::OP_SCAN_RD;
            state_in = ST_SCAN_MUL;
         end
         ST_SCAN_MUL: begin
            cmd.op   = ppc_pkg::OP_SCAN_MUL;
            state_in = ST_SCAN_ACC;
         end
         ST_SCAN_ACC: begin
            cmd.op = ppc_pkg::OP_SCAN_ACC;
            if (!status.scan_last) begin
               state_in = ST_SCAN_RD;
            end else if (!second_ff) begin
               second_in = 1'b1;
               state_in  = ST_LM_RDA;
            end else begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.op   = ppc_pkg::OP_INIT;
            phase_in = PH_MOVE;
            state_in = ST_IDLE;
         end
         ST_RD_CUR: begin
            cmd.op   = ppc_pkg::OP_RD_CUR;
            state_in = (phase_ff == PH_WALK) ? ST_RD_NEXT : ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = ppc_pkg::OP_SUM;
            state_in = ST_FIN;
         end
         ST_RD_NEXT: begin
            cmd.op   = ppc_pkg::OP_RD_NEXT;
            state_in = ST_RD_PREV;
         end
         ST_RD_PREV: begin
            cmd.op   = ppc_pkg::OP_RD_PREV;
            state_in = ST_CROSS1;
         end
         ST_CROSS1: begin
            cmd.op   = ppc_pkg::OP_CROSS1;
            state_in = ST_CROSS2;
         end
         ST_CROSS2: begin
            cmd.op   = ppc_pkg::OP_CROSS2;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.op   = ppc_pkg::OP_DECIDE;
            state_in = ST_FIN;
         end
         ST_CAP_STEP: begin
            cmd.cap_step = 1'b1;
            state_in     = ST_RD_CUR;
         end
         ST_FIN: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
            if (phase_ff == PH_MOVE) begin
               cmd.mv   = 1'b1;
               phase_in = PH_WALK;
            end else if (status.s_at_goal) begin
               if (!status.p_at_goal) begin
                  phase_in = PH_CAP;
               end else if (status.backward) begin
                  cmd.fin  = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  cmd.turn = 1'b1;
                  phase_in = PH_WALK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         second_ff <= second_in;
      end
   end

   `PPC_ASSERT_NEXT(a_move_then_walk, clock, reset, cmd.mv, phase_ff == PH_WALK)
   `PPC_ASSERT_NEXT(a_fin_then_done, clock, reset, cmd.fin, phase_ff == PH_DONE && !busy)
   `PPC_ASSERT_NEXT(a_walk_pull_reads, clock, reset, accept && req_command == ppc_pkg::CMD_PULL && phase_ff == PH_WALK, state_ff == ST_RD_CUR)

endmodule

>>> sv/ppc_dp.sv
// ---------------------------------------------------------------------------
// Polyline pen convolution datapath
// Point stores, walk positions, shared multiplier pair and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_dp #(
   parameter int PEN_POINTS    = ppc_pkg::PEN_POINTS_DEF,
   parameter int STROKE_POINTS = ppc_pkg::STROKE_POINTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ppc_pkg::dp_cmd_type    cmd,
   output ppc_pkg::dp_status_type status,
   input  logic [1:0]             req_command,
   input  logic signed [15:0]     req_x,
   input  logic signed [15:0]     req_y,
   input  logic                   req_last,
   output logic                   rsp_valid,
   output logic signed [15:0]     rsp_out_x,
   output logic signed [15:0]     rsp_out_y,
   output logic                   rsp_is_move,
   output logic                   rsp_end_of_outline
);

   localparam int PIW = (PEN_POINTS > 1) ? $clog2(PEN_POINTS) : 1;
   localparam int PCW = $clog2(PEN_POINTS + 1);
   localparam int SIW = (STROKE_POINTS > 1) ? $clog2(STROKE_POINTS) : 1;
   localparam int SCW = $clog2(STROKE_POINTS + 1);

   logic [PCW-1:0] pen_count_ff, pen_count_in;
   logic           pen_complete_ff, pen_complete_in;
   logic [SCW-1:0] stroke_count_ff, stroke_count_in;
   logic [SIW-1:0] stroke_pos_ff, stroke_pos_in;
   logic [SIW-1:0] stroke_goal_ff, stroke_goal_in;
   logic [PIW-1:0] pen_pos_ff, pen_pos_in;
   logic [PIW-1:0] pen_goal_ff, pen_goal_in;
   logic [PIW-1:0] start_vertex_ff, start_vertex_in;
   logic [PIW-1:0] return_vertex_ff, return_vertex_in;
   logic [PIW-1:0] scan_idx_ff, scan_idx_in;
   logic [PIW-1:0] best_idx_ff, best_idx_in;
   logic           walk_backward_ff, walk_backward_in;

   ppc_pkg::point_type s0_ff, s0_in, s1_ff, s1_in;
   ppc_pkg::point_type pc_ff, pc_in, pn_ff, pn_in, pm_ff, pm_in;
   logic signed [16:0] na_ff, na_in, nb_ff, nb_in;
   logic signed [33:0] prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic signed [34:0] best_ff, best_in;
   logic               c1_pos_ff, c1_pos_in;
   logic signed [15:0] ox_ff, ox_in, oy_ff, oy_in;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_move_ff, rsp_end_ff;

   logic               pen_we, stroke_we;
   logic [PIW-1:0]     pen_waddr, pen_raddr;
   logic [SIW-1:0]     stroke_waddr, stroke_raddr;
   logic [31:0]        pen_rdata, stroke_rdata, wdata;
   ppc_pkg::point_type pen_rd, str_rd;

   logic [PCW-1:0]     pc_base, pp_inc, pen_count_m1;
   logic               pen_room, str_room, stroke_ok;
   logic [SCW-1:0]     sc_base, sc_new, sc_m1, sc_m2;
   logic [PIW-1:0]     pn_idx, pm_idx, win_idx;
   logic [SIW-1:0]     sn_idx;
   logic signed [16:0] ma1, mb1, ma2, mb2;
   logic signed [16:0] adx, ady, bdx, bdy;
   logic signed [34:0] lm_sum, diff;
   logic               prod_en, win;
   ppc_pkg::point_type bsel1, bsel2, s_new, p_new;

   assign pen_rd = ppc_pkg::point_type'(pen_rdata);
   assign str_rd = ppc_pkg::point_type'(stroke_rdata);
   assign wdata  = {req_x, req_y};

   assign pc_base      = pen_complete_ff ? '0 : pen_count_ff;
   assign pen_room     = (pc_base < PCW'(PEN_POINTS));
   assign sc_base      = cmd.clear ? '0 : stroke_count_ff;
   assign str_room     = (sc_base < SCW'(STROKE_POINTS));
   assign sc_new       = sc_base + SCW'(str_room);
   assign stroke_ok    = (sc_new >= SCW'(2)) && pen_complete_ff && (pen_count_ff != '0);
   assign sc_m1        = stroke_count_ff - SCW'(1);
   assign sc_m2        = stroke_count_ff - SCW'(2);
   assign pen_count_m1 = pen_count_ff - PCW'(1);
   assign pp_inc       = PCW'(pen_pos_ff) + PCW'(1);
   assign pn_idx       = (pp_inc >= pen_count_ff) ? '0 : pp_inc[PIW-1:0];
   assign pm_idx       = (pen_pos_ff == '0) ? pen_count_m1[PIW-1:0] : pen_pos_ff - PIW'(1);
   assign sn_idx       = walk_backward_ff ? stroke_pos_ff - SIW'(1) : stroke_pos_ff + SIW'(1);

   assign adx    = 17'(s1_ff.x) - 17'(s0_ff.x);
   assign ady    = 17'(s1_ff.y) - 17'(s0_ff.y);
   assign bsel1  = (cmd.op == ppc_pkg::OP_CROSS1) ? pc_ff : pm_ff;
   assign bsel2  = (cmd.op == ppc_pkg::OP_CROSS1) ? pn_ff : pc_ff;
   assign bdx    = 17'(bsel2.x) - 17'(bsel1.x);
   assign bdy    = 17'(bsel2.y) - 17'(bsel1.y);
   assign lm_sum = 35'(prod1_ff) + 35'(prod2_ff);
   assign diff   = 35'(prod1_ff) - 35'(prod2_ff);
   assign prod1_in = ma1 * mb1;
   assign prod2_in = ma2 * mb2;

   assign status.stroke_start = (req_command == ppc_pkg::CMD_LOAD_STROKE) && req_last && stroke_ok;
   assign status.scan_last    = (scan_idx_ff == pen_count_m1[PIW-1:0]);
   assign status.s_at_goal    = (stroke_pos_ff == stroke_goal_ff);
   assign status.p_at_goal    = (pen_pos_ff == pen_goal_ff);
   assign status.backward     = walk_backward_ff;

   always_comb begin
      pen_count_in     = pen_count_ff;
      pen_complete_in  = pen_complete_ff;
      stroke_count_in  = stroke_count_ff;
      stroke_pos_in    = stroke_pos_ff;
      stroke_goal_in   = stroke_goal_ff;
      pen_pos_in       = pen_pos_ff;
      pen_goal_in      = pen_goal_ff;
      start_vertex_in  = start_vertex_ff;
      return_vertex_in = return_vertex_ff;
      scan_idx_in      = scan_idx_ff;
      best_idx_in      = best_idx_ff;
      walk_backward_in = walk_backward_ff;
      s0_in            = s0_ff;
      s1_in            = s1_ff;
      pc_in            = pc_ff;
      pn_in            = pn_ff;
      pm_in            = pm_ff;
      na_in            = na_ff;
      nb_in            = nb_ff;
      best_in          = best_ff;
      c1_pos_in        = c1_pos_ff;
      ox_in            = ox_ff;
      oy_in            = oy_ff;
      pen_we           = 1'b0;
      stroke_we        = 1'b0;
      pen_waddr        = pc_base[PIW-1:0];
      stroke_waddr     = sc_base[SIW-1:0];
      pen_raddr        = pen_pos_ff;
      stroke_raddr     = stroke_pos_ff;
      ma1              = ady;
      mb1              = bdx;
      ma2              = bdy;
      mb2              = adx;
      prod_en          = 1'b0;
      win              = 1'b0;
      win_idx          = best_idx_ff;
      s_new            = s0_ff;
      p_new            = pc_ff;
      case (cmd.op)
         ppc_pkg::OP_ACCEPT: begin
            if (cmd.clear) begin
               stroke_count_in = '0;
            end
            if (req_command == ppc_pkg::CMD_LOAD_PEN) begin
               pen_we          = pen_room;
               pen_count_in    = pen_room ? pc_base + PCW'(1) : pc_base;
               pen_complete_in = req_last;
            end else if (req_command == ppc_pkg::CMD_LOAD_STROKE) begin
               stroke_we       = str_room;
               stroke_count_in = (req_last && !stroke_ok) ? '0 : sc_new;
            end
         end
         ppc_pkg::OP_LM_RD_A: begin
            stroke_raddr = cmd.second ? sc_m1[SIW-1:0] : '0;
         end
         ppc_pkg::OP_LM_RD_B: begin
            s0_in        = str_rd;
            stroke_raddr = cmd.second ? sc_m2[SIW-1:0] : SIW'(1);
         end
         ppc_pkg::OP_LM_NORM: begin
            na_in       = 17'(str_rd.y) - 17'(s0_ff.y);
            nb_in       = 17'(s0_ff.x) - 17'(str_rd.x);
            scan_idx_in = '0;
         end
         ppc_pkg::OP_SCAN_RD: begin
            pen_raddr = scan_idx_ff;
         end
         ppc_pkg::OP_SCAN_MUL: begin
            ma1     = na_ff;
            mb1     = 17'(pen_rd.x);
            ma2     = nb_ff;
            mb2     = 17'(pen_rd.y);
            prod_en = 1'b1;
         end
         ppc_pkg::OP_SCAN_ACC: begin
            win = (scan_idx_ff == '0) || (lm_sum > best_ff);
            if (win) begin
               best_in     = lm_sum;
               best_idx_in = scan_idx_ff;
               win_idx     = scan_idx_ff;
            end
            if (status.scan_last) begin
               if (cmd.second) begin
                  return_vertex_in = win_idx;
               end else begin
                  start_vertex_in = win_idx;
               end
            end else begin
               scan_idx_in = scan_idx_ff + PIW'(1);
            end
         end
         ppc_pkg::OP_INIT: begin
            stroke_pos_in    = '0;
            pen_pos_in       = start_vertex_ff;
            stroke_goal_in   = sc_m1[SIW-1:0];
            pen_goal_in      = return_vertex_ff;
            walk_backward_in = 1'b0;
         end
         ppc_pkg::OP_RD_CUR: begin
            stroke_raddr = stroke_pos_ff;
            pen_raddr    = pen_pos_ff;
         end
         ppc_pkg::OP_SUM: begin
            ox_in = str_rd.x + pen_rd.x;
            oy_in = str_rd.y + pen_rd.y;
         end
         ppc_pkg::OP_RD_NEXT: begin
            s0_in        = str_rd;
            pc_in        = pen_rd;
            stroke_raddr = sn_idx;
            pen_raddr    = pn_idx;
         end
         ppc_pkg::OP_RD_PREV: begin
            s1_in     = str_rd;
            pn_in     = pen_rd;
            pen_raddr = pm_idx;
         end
         ppc_pkg::OP_CROSS1: begin
            pm_in   = pen_rd;
            prod_en = 1'b1;
         end
         ppc_pkg::OP_CROSS2: begin
            c1_pos_in = (diff > 35'sd0);
            prod_en   = 1'b1;
         end
         ppc_pkg::OP_DECIDE: begin
            if (c1_pos_ff) begin
               pen_pos_in = pn_idx;
               p_new      = pn_ff;
            end else if (diff < 35'sd0) begin
               pen_pos_in = pm_idx;
               p_new      = pm_ff;
            end else begin
               stroke_pos_in = sn_idx;
               s_new         = s1_ff;
            end
            ox_in = s_new.x + p_new.x;
            oy_in = s_new.y + p_new.y;
         end
         default: begin
         end
      endcase
      if (cmd.cap_step) begin
         pen_pos_in = pn_idx;
      end
      if (cmd.turn) begin
         walk_backward_in = 1'b1;
         stroke_goal_in   = '0;
         pen_goal_in      = start_vertex_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_count_ff     <= '0;
         pen_complete_ff  <= 1'b0;
         stroke_count_ff  <= '0;
         stroke_pos_ff    <= '0;
         stroke_goal_ff   <= '0;
         pen_pos_ff       <= '0;
         pen_goal_ff      <= '0;
         start_vertex_ff  <= '0;
         return_vertex_ff <= '0;
         walk_backward_ff <= 1'b0;
         scan_idx_ff      <= '0;
         best_idx_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pen_count_ff     <= pen_count_in;
         pen_complete_ff  <= pen_complete_in;
         stroke_count_ff  <= stroke_count_in;
         stroke_pos_ff    <= stroke_pos_in;
         stroke_goal_ff   <= stroke_goal_in;
         pen_pos_ff       <= pen_pos_in;
         pen_goal_ff      <= pen_goal_in;
         start_vertex_ff  <= start_vertex_in;
         return_vertex_ff <= return_vertex_in;
         walk_backward_ff <= walk_backward_in;
         scan_idx_ff      <= scan_idx_in;
         best_idx_ff      <= best_idx_in;
         rsp_valid_ff     <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
      pc_ff     <= pc_in;
      pn_ff     <= pn_in;
      pm_ff     <= pm_in;
      na_ff     <= na_in;
      nb_ff     <= nb_in;
      best_ff   <= best_in;
      c1_pos_ff <= c1_pos_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      if (prod_en) begin
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
      end
      if (cmd.emit) begin
         rsp_x_ff    <= ox_ff;
         rsp_y_ff    <= oy_ff;
         rsp_move_ff <= cmd.mv;
         rsp_end_ff  <= cmd.fin;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_x          = rsp_x_ff;
   assign rsp_out_y          = rsp_y_ff;
   assign rsp_is_move        = rsp_move_ff;
   assign rsp_end_of_outline = rsp_end_ff;

   ppc_ram #(
      .WIDTH (32),
      .DEPTH (PEN_POINTS)
   ) u_pen_ram (
      .clock   (clock),
      .wr_en   (pen_we),
      .wr_addr (pen_waddr),
      .wr_data (wdata),
      .rd_addr (pen_raddr),
      .rd_data (pen_rdata)
   );

   ppc_ram #(
      .WIDTH (32),
      .DEPTH (STROKE_POINTS)
   ) u_stroke_ram (
      .clock   (clock),
      .wr_en   (stroke_we),
      .wr_addr (stroke_waddr),
      .wr_data (wdata),
      .rd_addr (stroke_raddr),
      .rd_data (stroke_rdata)
   );

endmodule

>>> sv/polyline_pen_convolution.sv
// ---------------------------------------------------------------------------
// Polyline pen convolution top level
// Loads a convex pen and one stroke subpath, then yields outline points.
// Pen load, or stroke point not ending a valid subpath: busy stays low.
// Stroke point ending a valid subpath: busy while both leftmost-vertex scans
// run over the pen RAM, one vertex at a time (read, multiply, accumulate).
// Pull: a strobe follows for a move, a cap step or a walk step (a walk step
// needs three serial RAM reads and two cross products on one multiplier
// pair); a pull with no outline running gives no strobe.
// Synchronous reset clears counts and the outline; the stores are not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyline_pen_convolution #(
   parameter int PEN_POINTS    = ppc_pkg::PEN_POINTS_DEF,
   parameter int STROKE_POINTS = ppc_pkg::STROKE_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic signed [15:0] req_x,
   input  logic signed [15:0] req_y,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic               rsp_is_move,
   output logic               rsp_end_of_outline
);

   ppc_pkg::dp_cmd_type    cmd;
   ppc_pkg::dp_status_type status;

   ppc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .busy        (busy),
      .cmd         (cmd),
      .status      (status)
   );

   ppc_dp #(
      .PEN_POINTS    (PEN_POINTS),
      .STROKE_POINTS (STROKE_POINTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_command        (req_command),
      .req_x              (req_x),
      .req_y              (req_y),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_is_move        (rsp_is_move),
      .rsp_end_of_outline (rsp_end_of_outline)
   );

endmodule
